FILE: hw/rtl/depth_pixel_registration_macros.svh
// ----------------------------------------------------------------------------
// Depth pixel registration assertion macros
// Small wrappers for the concurrent checks of the registration block.
// ----------------------------------------------------------------------------
`ifndef DEPTH_PIXEL_REGISTRATION_MACROS_SVH
`define DEPTH_PIXEL_REGISTRATION_MACROS_SVH
`ifndef NO_ASSERTIONS
// condition must never hold outside reset
`define DPR_ASSERT_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("check failed");
// antecedent implies consequent in the same cycle, outside reset
`define DPR_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("check failed");
// antecedent implies consequent in the next cycle, checked through reset
`define DPR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("check failed");
`else
`define DPR_ASSERT_NEVER(label, cond)
`define DPR_ASSERT_IMPL(label, ante, cons)
`define DPR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hw/rtl/dpr_pkg.sv
// ----------------------------------------------------------------------------
// Depth pixel registration package
// Frame geometry, table sizes, codes and the queue word type.
// ----------------------------------------------------------------------------
package dpr_pkg;

   localparam int FRAME_WIDTH    = 640;
   localparam int FRAME_HEIGHT   = 480;
   localparam int RAW_LEVELS     = 2048;
   localparam int MAX_DEPTH_MM   = 10000;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

   // item modes
   typedef enum logic [1:0] {
      MODE_LOAD_MM    = 2'd0,
      MODE_LOAD_SHIFT = 2'd1,
      MODE_PIXEL      = 2'd2
   } mode_type;

   // register indexes
   typedef enum logic [1:0] {
      CSR_LINE_OFFSET  = 2'd0,
      CSR_PIXEL_SIZE   = 2'd1,
      CSR_PLANE_DIST   = 2'd2
   } csr_index_type;

   // word handed from front to back
   typedef struct packed {
      logic [13:0]        metric_z;
      logic [9:0]         column;
      logic [8:0]         row;
      logic signed [31:0] reg_x;
      logic signed [31:0] reg_y;
      logic signed [31:0] shift;
   } dpr_entry_type;

endpackage

FILE: hw/rtl/dpr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dpr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hw/rtl/dpr_front.sv
// ----------------------------------------------------------------------------
// Depth pixel registration front end
// Accepts words, loads the tables, looks up depth and shift, feeds the queue.
// ----------------------------------------------------------------------------
module dpr_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_mode,
   input  logic [13:0]                   req_table_index,
   input  logic signed [31:0]            req_table_value,
   input  logic [10:0]                   req_raw_depth,
   input  logic [9:0]                    req_column,
   input  logic [8:0]                    req_row,
   input  logic signed [31:0]            req_reg_x,
   input  logic signed [31:0]            req_reg_y,
   input  logic [dpr_pkg::QCNT_W-1:0]    queue_level,
   output logic                          push,
   output dpr_pkg::dpr_entry_type        push_data
);
   import dpr_pkg::*;

   logic               accept;
   logic               mm_we;
   logic [15:0]        mm_rd;
   logic [13:0]        depth_in;
   logic [13:0]        shift_idx;
   logic [31:0]        shift_rd;

   logic               s0_pix_ff, s0_ld_ff;
   logic [13:0]        s0_idx_ff;
   logic [31:0]        s0_val_ff;
   logic [9:0]         s0_col_ff;
   logic [8:0]         s0_row_ff;
   logic signed [31:0] s0_rx_ff, s0_ry_ff;
   logic               s1_pix_ff;
   logic [13:0]        s1_z_ff;
   logic [9:0]         s1_col_ff;
   logic [8:0]         s1_row_ff;
   logic signed [31:0] s1_rx_ff, s1_ry_ff;

   // credit check: queue plus words in flight must fit
   assign req_stall = (QCNT_W'(queue_level) + QCNT_W'(s0_pix_ff) + QCNT_W'(s1_pix_ff))
                      >= QCNT_W'(QUEUE_DEPTH);
   assign accept = req_valid & ~req_stall;
   assign mm_we  = accept && (req_mode == MODE_LOAD_MM)
                   && (req_table_index < 14'(RAW_LEVELS));

   dpr_ram #(.WIDTH(16), .DEPTH(RAW_LEVELS)) u_mm_ram (
      .clock   (clock),
      .wr_en   (mm_we),
      .wr_addr (req_table_index[10:0]),
      .wr_data (req_table_value[15:0]),
      .rd_addr (req_raw_depth),
      .rd_data (mm_rd)
   );

   // stage 0 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_pix_ff <= 1'b0;
         s0_ld_ff  <= 1'b0;
      end else begin
         s0_pix_ff <= accept && (req_mode == MODE_PIXEL);
         s0_ld_ff  <= accept && (req_mode == MODE_LOAD_SHIFT)
                      && (req_table_index < 14'(MAX_DEPTH_MM));
      end
      s0_idx_ff <= req_table_index;
      s0_val_ff <= req_table_value;
      s0_col_ff <= req_column;
      s0_row_ff <= req_row;
      s0_rx_ff  <= req_reg_x;
      s0_ry_ff  <= req_reg_y;
   end

   // depth clamp and shift table index
   always_comb begin
      depth_in  = (mm_rd > 16'(MAX_DEPTH_MM)) ? 14'(MAX_DEPTH_MM) : mm_rd[13:0];
      shift_idx = (depth_in == 14'(MAX_DEPTH_MM)) ? 14'(MAX_DEPTH_MM - 1) : depth_in;
   end

   // shift writes sit at the same stage as shift reads, keeping item order
   dpr_ram #(.WIDTH(32), .DEPTH(MAX_DEPTH_MM)) u_shift_ram (
      .clock   (clock),
      .wr_en   (s0_ld_ff),
      .wr_addr (s0_idx_ff),
      .wr_data (s0_val_ff),
      .rd_addr (shift_idx),
      .rd_data (shift_rd)
   );

   // stage 1 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_pix_ff <= 1'b0;
      end else begin
         s1_pix_ff <= s0_pix_ff;
      end
      s1_z_ff   <= depth_in;
      s1_col_ff <= s0_col_ff;
      s1_row_ff <= s0_row_ff;
      s1_rx_ff  <= s0_rx_ff;
      s1_ry_ff  <= s0_ry_ff;
   end

   assign push = s1_pix_ff;
   always_comb begin
      push_data.metric_z = s1_z_ff;
      push_data.column   = s1_col_ff;
      push_data.row      = s1_row_ff;
      push_data.reg_x    = s1_rx_ff;
      push_data.reg_y    = s1_ry_ff;
      push_data.shift    = shift_rd;
   end
endmodule

FILE: hw/rtl/dpr_fifo.sv
// ----------------------------------------------------------------------------
// Depth pixel registration queue
// Short word queue between front and back ends.
// ----------------------------------------------------------------------------
module dpr_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  dpr_pkg::dpr_entry_type     push_data,
   input  logic                       pop,
   output dpr_pkg::dpr_entry_type     pop_data,
   output logic [dpr_pkg::QCNT_W-1:0] level
);
   import dpr_pkg::*;

   dpr_entry_type     mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wp_ff, rp_ff;
   logic [QCNT_W-1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= wp_ff + QPTR_W'(1);
         end
         if (pop) begin
            rp_ff <= rp_ff + QPTR_W'(1);
         end
         cnt_ff <= cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
      end
      if (push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rp_ff];
   assign level    = cnt_ff;
endmodule

FILE: hw/rtl/dpr_back.sv
// ----------------------------------------------------------------------------
// Depth pixel registration back end
// Color index, world scale products, pipelined divide and output register.
// ----------------------------------------------------------------------------
module dpr_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [7:0]                 line_offset,
   input  logic [15:0]                pixel_size,
   input  logic [15:0]                plane_dist,
   input  logic [dpr_pkg::QCNT_W-1:0] queue_level,
   output logic                       pop,
   input  dpr_pkg::dpr_entry_type     pop_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [13:0]                rsp_metric_z,
   output logic signed [15:0]         rsp_world_x,
   output logic signed [15:0]         rsp_world_y,
   output logic                       rsp_color_valid,
   output logic [18:0]                rsp_color_index
);
   import dpr_pkg::*;

   localparam int STEPS = 16;

   typedef struct packed {
      logic        neg;
      logic        sat;
      logic [15:0] rem;
      logic [15:0] num;
      logic [15:0] quo;
   } lane_type;

   typedef struct packed {
      logic [13:0] z;
      logic        cv;
      logic [18:0] ci;
   } meta_type;

   // one restoring divide step
   function automatic lane_type div_step(lane_type l, logic [15:0] d);
      lane_type   r;
      logic [16:0] trial;
      r     = l;
      trial = {l.rem, l.num[15]};
      r.num = {l.num[14:0], 1'b0};
      if (trial >= {1'b0, d}) begin
         r.rem = 16'(trial - {1'b0, d});
         r.quo = {l.quo[14:0], 1'b1};
      end else begin
         r.rem = trial[15:0];
         r.quo = {l.quo[14:0], 1'b0};
      end
      return r;
   endfunction

   // quotient to signed 16 bits with saturation
   function automatic logic [15:0] saturate(lane_type l);
      logic [15:0] r;
      if (l.neg) begin
         r = (l.sat || l.quo > 16'd32768) ? 16'h8000 : 16'(-l.quo);
      end else begin
         r = (l.sat || l.quo > 16'd32767) ? 16'h7FFF : l.quo;
      end
      return r;
   endfunction

   logic               en;
   logic [15:0]        rd_eff;
   logic signed [10:0] offx, offy;
   logic [9:0]         magx, magy;
   logic signed [32:0] csum, cq;
   logic signed [43:0] ci_w;

   logic               b1_v_ff;
   logic [13:0]        b1_z_ff;
   logic               b1_nx_ff, b1_ny_ff;
   logic [25:0]        b1_px_ff, b1_py_ff;
   logic signed [24:0] b1_cx_ff;
   logic signed [31:0] b1_ry_ff;

   logic               b2_v_ff;
   logic [32:0]        b2_nx_ff, b2_ny_ff;
   logic               b2_negx_ff, b2_negy_ff;
   meta_type           b2_meta_ff;

   logic               st_v_ff [STEPS+1];
   lane_type           st_x_ff [STEPS+1];
   lane_type           st_y_ff [STEPS+1];
   meta_type           st_m_ff [STEPS+1];

   logic               out_v_ff;
   logic [13:0]        out_z_ff;
   logic [15:0]        out_x_ff, out_y_ff;
   logic               out_cv_ff;
   logic [18:0]        out_ci_ff;

   // whole pipeline moves when the output register can take a word
   assign en     = ~out_v_ff | ~rsp_stall;
   assign pop    = en && (queue_level != '0);
   assign rd_eff = (plane_dist == 16'd0) ? 16'd1 : plane_dist;

   // offsets from frame center and color column
   always_comb begin
      offx = $signed({1'b0, pop_data.column}) - 11'(FRAME_WIDTH / 2);
      offy = $signed({2'b0, pop_data.row}) - 11'(FRAME_HEIGHT / 2);
      magx = offx[10] ? 10'(-offx) : offx[9:0];
      magy = offy[10] ? 10'(-offy) : offy[9:0];
      csum = 33'(pop_data.reg_x) + 33'(pop_data.shift);
      cq   = csum >>> 8;
      if (csum[32] && (csum[7:0] != 8'd0)) begin
         cq = cq + 33'sd1;
      end
   end

   // color index from stage 1
   assign ci_w = 44'(b1_ry_ff) * 44'(FRAME_WIDTH) + 44'(b1_cx_ff)
                 - 44'(line_offset) * 44'(FRAME_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff  <= 1'b0;
         b2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         for (int k = 0; k <= STEPS; k++) begin
            st_v_ff[k] <= 1'b0;
         end
      end else if (en) begin
         b1_v_ff    <= pop;
         b2_v_ff    <= b1_v_ff;
         st_v_ff[0] <= b2_v_ff;
         for (int k = 1; k <= STEPS; k++) begin
            st_v_ff[k] <= st_v_ff[k-1];
         end
         out_v_ff <= st_v_ff[STEPS];
      end
      if (en) begin
         // stage 1: first products and color column
         b1_z_ff  <= pop_data.metric_z;
         b1_nx_ff <= offx[10];
         b1_ny_ff <= offy[10];
         b1_px_ff <= 26'(magx) * 26'(pixel_size);
         b1_py_ff <= 26'(magy) * 26'(pixel_size);
         b1_cx_ff <= cq[24:0];
         b1_ry_ff <= pop_data.reg_y;
         // stage 2: times depth, scale of 2/256 folded into a shift by 7
         b2_nx_ff   <= 33'((40'(b1_px_ff) * 40'(b1_z_ff)) >> 7);
         b2_ny_ff   <= 33'((40'(b1_py_ff) * 40'(b1_z_ff)) >> 7);
         b2_negx_ff <= b1_nx_ff;
         b2_negy_ff <= b1_ny_ff;
         b2_meta_ff.z  <= b1_z_ff;
         b2_meta_ff.cv <= !b1_cx_ff[24] && (b1_cx_ff < 25'(FRAME_WIDTH))
                          && !ci_w[43]
                          && (ci_w < 44'(FRAME_WIDTH * FRAME_HEIGHT));
         b2_meta_ff.ci <= ci_w[18:0];
         // divider setup: quotient of 16 bits or saturated
         st_x_ff[0].neg <= b2_negx_ff;
         st_x_ff[0].sat <= b2_nx_ff >= {1'b0, rd_eff, 16'd0};
         st_x_ff[0].rem <= b2_nx_ff[31:16];
         st_x_ff[0].num <= b2_nx_ff[15:0];
         st_x_ff[0].quo <= '0;
         st_y_ff[0].neg <= b2_negy_ff;
         st_y_ff[0].sat <= b2_ny_ff >= {1'b0, rd_eff, 16'd0};
         st_y_ff[0].rem <= b2_ny_ff[31:16];
         st_y_ff[0].num <= b2_ny_ff[15:0];
         st_y_ff[0].quo <= '0;
         st_m_ff[0]     <= b2_meta_ff;
         // divide steps
         for (int k = 1; k <= STEPS; k++) begin
            st_x_ff[k] <= div_step(st_x_ff[k-1], rd_eff);
            st_y_ff[k] <= div_step(st_y_ff[k-1], rd_eff);
            st_m_ff[k] <= st_m_ff[k-1];
         end
         // output register
         out_z_ff  <= st_m_ff[STEPS].z;
         out_x_ff  <= saturate(st_x_ff[STEPS]);
         out_y_ff  <= saturate(st_y_ff[STEPS]);
         out_cv_ff <= st_m_ff[STEPS].cv;
         out_ci_ff <= st_m_ff[STEPS].cv ? st_m_ff[STEPS].ci : 19'd0;
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_metric_z    = out_z_ff;
   assign rsp_world_x     = out_x_ff;
   assign rsp_world_y     = out_y_ff;
   assign rsp_color_valid = out_cv_ff;
   assign rsp_color_index = out_ci_ff;
endmodule

FILE: hw/rtl/depth_pixel_registration.sv
// ----------------------------------------------------------------------------
// Depth pixel registration
// Depth to metric, world coordinates and color source index per pixel.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word per accepted cycle (req_valid high, req_stall low).
//   Mode load-mm writes the millimeter table, mode load-shift writes the
//   shift table; neither gives a response. Mode pixel gives one rsp_* word.
//   csr_* writes line_offset, pixel_size, plane_dist; csr_ready is always
//   high. Write registers only while the block is idle.
//   Throughput: one word per cycle when nothing stalls. A pixel passes from
//   the accepting edge to rsp_valid through the depth lookup at the accepting
//   edge, then the shift lookup stage, the queue, two product stages, one
//   divider setup stage, 16 divide steps and the output register. The
//   divider gives one quotient bit per step for 16 bits.
//   A stalled response freezes the back end; the four-word queue fills and
//   the front raises req_stall once queue plus words in flight reach four.
//   Reset clears control state and registers to their defaults. Table
//   contents are undefined until written.
// ----------------------------------------------------------------------------
`include "depth_pixel_registration_macros.svh"

module depth_pixel_registration (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_mode,
   input  logic [13:0]         req_table_index,
   input  logic signed [31:0]  req_table_value,
   input  logic [10:0]         req_raw_depth,
   input  logic [9:0]          req_column,
   input  logic [8:0]          req_row,
   input  logic signed [31:0]  req_reg_x,
   input  logic signed [31:0]  req_reg_y,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [13:0]         rsp_metric_z,
   output logic signed [15:0]  rsp_world_x,
   output logic signed [15:0]  rsp_world_y,
   output logic                rsp_color_valid,
   output logic [18:0]         rsp_color_index,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data
);
   import dpr_pkg::*;

   logic [7:0]        line_offset_ff;
   logic [15:0]       pixel_size_ff;
   logic [15:0]       plane_dist_ff;
   logic [QCNT_W-1:0] queue_level;
   logic              push, pop;
   dpr_entry_type     push_data, pop_data;

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         line_offset_ff <= 8'd0;
         pixel_size_ff  <= 16'd6828;
         plane_dist_ff  <= 16'd30720;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LINE_OFFSET: line_offset_ff <= csr_data[7:0];
            CSR_PIXEL_SIZE:  pixel_size_ff  <= csr_data[15:0];
            CSR_PLANE_DIST:  plane_dist_ff  <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   dpr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_table_index (req_table_index),
      .req_table_value (req_table_value),
      .req_raw_depth   (req_raw_depth),
      .req_column      (req_column),
      .req_row         (req_row),
      .req_reg_x       (req_reg_x),
      .req_reg_y       (req_reg_y),
      .queue_level     (queue_level),
      .push            (push),
      .push_data       (push_data)
   );

   dpr_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .level     (queue_level)
   );

   dpr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .line_offset     (line_offset_ff),
      .pixel_size      (pixel_size_ff),
      .plane_dist      (plane_dist_ff),
      .queue_level     (queue_level),
      .pop             (pop),
      .pop_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_metric_z    (rsp_metric_z),
      .rsp_world_x     (rsp_world_x),
      .rsp_world_y     (rsp_world_y),
      .rsp_color_valid (rsp_color_valid),
      .rsp_color_index (rsp_color_index)
   );

   // checks
   `DPR_ASSERT_NEVER(a_queue_bound, queue_level > QCNT_W'(QUEUE_DEPTH))
   `DPR_ASSERT_IMPL(a_pop_nonempty, pop, queue_level != '0)
   `DPR_ASSERT_IMPL(a_full_push_pops, push && (queue_level == QCNT_W'(QUEUE_DEPTH)), pop)
   `DPR_ASSERT_NEXT(a_reset_idle, reset, !rsp_valid && !push)
endmodule
